// ===== rtl/pcfc_pkg.sv =====
// shared types and constants of the periodic command frame composer
package pcfc_pkg;

    localparam logic [6:0] THROTTLE_MAX    = 7'd100;
    localparam logic [7:0] DEFAULT_MODULUS = 8'd16;
    localparam logic [7:0] DEFAULT_PERIOD  = 8'd1;
    localparam int unsigned DIV_STEPS      = 8;

    localparam logic [1:0] REG_MIN_PERIOD  = 2'd0;
    localparam logic [1:0] REG_ON_CHANGE   = 2'd1;
    localparam logic [1:0] REG_ALIVE_MOD   = 2'd2;

    typedef struct packed {
        logic start;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
    } dp_status_t;

endpackage

// ===== rtl/pcfc_ctrl.sv =====
// controller: beat acceptance, modulo sequencing and output slot
module pcfc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pcfc_pkg::dp_status_t status,
    output pcfc_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;
    logic        accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                cmd.start = accept;
                if (accept && status.emit)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 3'd1;
                if (step_reg == 3'(pcfc_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/pcfc_dp.sv =====
// datapath: registers, tick budget, change compare, remainder unit, frame register
module pcfc_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 sample_valid,
    input  logic [7:0]           throttle_pct,
    input  logic [3:0]           gear_code,
    input  logic [3:0]           mode_code,
    input  logic [7:0]           flag_bits,
    input  logic                 brake_on,
    input  logic                 sink_accepts,
    input  pcfc_pkg::dp_cmd_t    cmd,
    output pcfc_pkg::dp_status_t status,
    output logic [6:0]           throttle_out,
    output logic [3:0]           gear_out,
    output logic [3:0]           mode_out,
    output logic                 brake_out,
    output logic [7:0]           alive_out
);

    logic [7:0] min_period_reg;
    logic       on_change_reg;
    logic [7:0] alive_mod_reg;

    logic [7:0] budget_reg;
    logic [7:0] alive_cnt_reg;
    logic       have_prev_reg;
    logic [7:0] prev_thr_reg;
    logic [3:0] prev_gear_reg;
    logic [3:0] prev_mode_reg;
    logic [7:0] prev_flags_reg;
    logic       prev_brake_reg;

    logic [6:0] thr_reg;
    logic [3:0] gear_reg;
    logic [3:0] mode_reg;
    logic       brake_reg;
    logic [7:0] dvd_reg;
    logic [7:0] divisor_reg;
    logic [7:0] rem_reg;

    logic [6:0] thr_out_reg;
    logic [3:0] gear_out_reg;
    logic [3:0] mode_out_reg;
    logic       brake_out_reg;
    logic [7:0] alive_out_reg;

    logic [7:0] period_m1;
    logic [7:0] modulus;
    logic       qualify;
    logic       same;
    logic       emit;
    logic [8:0] trial;
    logic       fits;
    logic [7:0] rem_next;

    assign period_m1 = (min_period_reg == 8'd0) ? 8'd0 : (min_period_reg - 8'd1);
    assign modulus   = (alive_mod_reg == 8'd0) ? pcfc_pkg::DEFAULT_MODULUS : alive_mod_reg;
    assign qualify   = (budget_reg >= period_m1);
    assign same      = have_prev_reg && (throttle_pct == prev_thr_reg)
                       && (gear_code == prev_gear_reg) && (mode_code == prev_mode_reg)
                       && (flag_bits == prev_flags_reg) && (brake_on == prev_brake_reg);
    assign emit      = qualify && sample_valid && !(on_change_reg && same);
    assign status.emit = emit;

    // one quotient bit per step, only the remainder is kept
    assign trial    = {rem_reg, dvd_reg[7]};
    assign fits     = (trial >= {1'b0, divisor_reg});
    assign rem_next = fits ? 8'(trial - {1'b0, divisor_reg}) : trial[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= pcfc_pkg::DEFAULT_PERIOD;
            on_change_reg  <= 1'b0;
            alive_mod_reg  <= pcfc_pkg::DEFAULT_MODULUS;
            budget_reg     <= '0;
            alive_cnt_reg  <= '0;
            have_prev_reg  <= 1'b0;
            prev_thr_reg   <= '0;
            prev_gear_reg  <= '0;
            prev_mode_reg  <= '0;
            prev_flags_reg <= '0;
            prev_brake_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    pcfc_pkg::REG_MIN_PERIOD: min_period_reg <= cfg_wdata;
                    pcfc_pkg::REG_ON_CHANGE:  on_change_reg  <= cfg_wdata[0];
                    pcfc_pkg::REG_ALIVE_MOD:  alive_mod_reg  <= cfg_wdata;
                    default:                  ;
                endcase
            end
            if (cmd.start)
            begin
                budget_reg <= qualify ? 8'd0 : (budget_reg + 8'd1);
                if (emit && sink_accepts)
                begin
                    alive_cnt_reg  <= alive_cnt_reg + 8'd1;
                    have_prev_reg  <= 1'b1;
                    prev_thr_reg   <= throttle_pct;
                    prev_gear_reg  <= gear_code;
                    prev_mode_reg  <= mode_code;
                    prev_flags_reg <= flag_bits;
                    prev_brake_reg <= brake_on;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            thr_reg     <= (throttle_pct > {1'b0, pcfc_pkg::THROTTLE_MAX})
                           ? pcfc_pkg::THROTTLE_MAX : throttle_pct[6:0];
            gear_reg    <= gear_code;
            mode_reg    <= mode_code;
            brake_reg   <= brake_on;
            dvd_reg     <= alive_cnt_reg;
            divisor_reg <= modulus;
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[6:0], 1'b0};
        end
        if (cmd.load_out)
        begin
            thr_out_reg   <= thr_reg;
            gear_out_reg  <= gear_reg;
            mode_out_reg  <= mode_reg;
            brake_out_reg <= brake_reg;
            alive_out_reg <= rem_reg;
        end
    end

    assign throttle_out = thr_out_reg;
    assign gear_out     = gear_out_reg;
    assign mode_out     = mode_out_reg;
    assign brake_out    = brake_out_reg;
    assign alive_out    = alive_out_reg;

endmodule

// ===== rtl/periodic_command_frame_composer.sv =====
// top level of the periodic command frame composer
// One input beat is one scheduler tick. A tick that sends no frame leaves the block
// in idle, ready for the next tick. A tick that sends a frame is taken from idle,
// then the bit-serial remainder unit reduces the alive counter by the modulus, and
// then the frame is loaded into the output register; the load waits while an earlier
// frame is still unclaimed. A new tick can be taken while a finished frame waits at
// the output. Configuration writes are registered and should be made only while the
// block is idle.
module periodic_command_frame_composer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       sample_valid,
    input  logic [7:0] throttle_pct,
    input  logic [3:0] gear_code,
    input  logic [3:0] mode_code,
    input  logic [7:0] flag_bits,
    input  logic       brake_on,
    input  logic       sink_accepts,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] throttle_out,
    output logic [3:0] gear_out,
    output logic [3:0] mode_out,
    output logic       brake_out,
    output logic [7:0] alive_out
);

    pcfc_pkg::dp_cmd_t    cmd;
    pcfc_pkg::dp_status_t status;

    pcfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pcfc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .throttle_pct (throttle_pct),
        .gear_code    (gear_code),
        .mode_code    (mode_code),
        .flag_bits    (flag_bits),
        .brake_on     (brake_on),
        .sink_accepts (sink_accepts),
        .cmd          (cmd),
        .status       (status),
        .throttle_out (throttle_out),
        .gear_out     (gear_out),
        .mode_out     (mode_out),
        .brake_out    (brake_out),
        .alive_out    (alive_out)
    );

endmodule

// ===== rtl/pcfc_checker.sv =====
// port-level checker for the periodic command frame composer, with its bind
module pcfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       sample_valid,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] throttle_out,
    input logic [7:0] alive_out
);

    // a waiting frame holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(throttle_out) && $stable(alive_out))
        else $error("frame changed while stalled");

    a_thr_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> throttle_out <= 7'd100)
        else $error("throttle not clamped");

    // the remainder unit lies between beat and frame, so a frame never follows its beat at once
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("frame appeared too early");

    // an invalid sample sends nothing and leaves the block ready
    a_invalid_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !sample_valid |=> in_ready)
        else $error("invalid sample started a frame");

endmodule

bind periodic_command_frame_composer pcfc_checker u_pcfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_valid (sample_valid),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .throttle_out (throttle_out),
    .alive_out    (alive_out)
);

// ===== tb/tb_periodic_command_frame_composer.sv =====
// self-checking testbench for the periodic command frame composer
`timescale 1ns / 1ps

module tb_periodic_command_frame_composer;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int N_DIRECTED = 35;
    localparam int N_PHASES = 8;
    localparam int TICKS_PER_PHASE = 244;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic       sample_valid;
        logic [7:0] throttle;
        logic [3:0] gear;
        logic [3:0] mode;
        logic [7:0] flags;
        logic       brake;
        logic       accept;
    } tick_t;

    typedef struct packed {
        logic [6:0] throttle;
        logic [3:0] gear;
        logic [3:0] mode;
        logic       brake;
        logic [7:0] alive;
    } frame_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_FRAME, ROW_SILENT} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [1:0] idx;
        logic [7:0] data;
        tick_t      tick;
        frame_t     frame;
    } row_t;

    localparam tick_t  NO_TICK  = '0;
    localparam frame_t NO_FRAME = '0;

    localparam row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_FRAME,   REG_SPARE, 8'h00, '{1'b1, 8'd0,   4'h0, 4'h0, 8'h00, 1'b0, 1'b1},
          '{7'd0,   4'h0, 4'h0, 1'b0, 8'd0}},
        '{ROW_FRAME,   REG_SPARE, 8'h00, '{1'b1, 8'd255, 4'hF, 4'hF, 8'hFF, 1'b1, 1'b1},
          '{7'd100, 4'hF, 4'hF, 1'b1, 8'd1}},
        '{ROW_FRAME,   REG_SPARE, 8'h00, '{1'b1, 8'd100, 4'h3, 4'h4, 8'h0F, 1'b0, 1'b0},
          '{7'd100, 4'h3, 4'h4, 1'b0, 8'd2}},
        '{ROW_FRAME,   REG_SPARE, 8'h00, '{1'b1, 8'd101, 4'h3, 4'h4, 8'h0F, 1'b0, 1'b1},
          '{7'd100, 4'h3, 4'h4, 1'b0, 8'd2}},
        '{ROW_SILENT,  REG_SPARE, 8'h00, '{1'b0, 8'hA5, 4'hA, 4'h5, 8'h5A, 1'b1, 1'b1},
          NO_FRAME},
        '{ROW_FRAME,   REG_SPARE, 8'h00, '{1'b1, 8'd99,  4'h1, 4'h2, 8'h00, 1'b1, 1'b1},
          '{7'd99,  4'h1, 4'h2, 1'b1, 8'd3}},
        '{ROW_CFG,     pcfc_pkg::REG_ON_CHANGE, 8'h01, NO_TICK, NO_FRAME},
        '{ROW_SILENT,  REG_SPARE, 8'h00, '{1'b1, 8'd99,  4'h1, 4'h2, 8'h00, 1'b1, 1'b1},
          NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd99,  4'h1, 4'h2, 8'h01, 1'b1, 1'b0},
          NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd99,  4'h1, 4'h2, 8'h01, 1'b1, 1'b1},
          NO_FRAME},
        '{ROW_SILENT,  REG_SPARE, 8'h00, '{1'b1, 8'd99,  4'h1, 4'h2, 8'h01, 1'b1, 1'b1},
          NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd99,  4'h1, 4'h2, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd200, 4'h1, 4'h2, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd201, 4'h1, 4'h2, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_CFG,     pcfc_pkg::REG_ALIVE_MOD, 8'h00, NO_TICK, NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd50,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_CFG,     pcfc_pkg::REG_ALIVE_MOD, 8'h01, NO_TICK, NO_FRAME},
        '{ROW_FRAME,   REG_SPARE, 8'h00, '{1'b1, 8'd51,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          '{7'd51,  4'h6, 4'h7, 1'b0, 8'd0}},
        '{ROW_CFG,     pcfc_pkg::REG_ALIVE_MOD, 8'hFF, NO_TICK, NO_FRAME},
        '{ROW_CFG,     pcfc_pkg::REG_MIN_PERIOD, 8'h00, NO_TICK, NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd52,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_CFG,     pcfc_pkg::REG_MIN_PERIOD, 8'h03, NO_TICK, NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd53,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd54,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd55,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_CFG,     pcfc_pkg::REG_MIN_PERIOD, 8'hFF, NO_TICK, NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd56,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd57,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd58,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_CFG,     pcfc_pkg::REG_MIN_PERIOD, 8'h01, NO_TICK, NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd59,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_CFG,     REG_SPARE, 8'hFF, NO_TICK, NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd60,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME},
        '{ROW_CFG,     pcfc_pkg::REG_ON_CHANGE, 8'hFE, NO_TICK, NO_FRAME},
        '{ROW_PREDICT, REG_SPARE, 8'h00, '{1'b1, 8'd60,  4'h6, 4'h7, 8'h01, 1'b0, 1'b1},
          NO_FRAME}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write_en = 1'b0;
    logic [1:0] cfg_index = pcfc_pkg::REG_MIN_PERIOD;
    logic [7:0] cfg_wdata = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       sample_valid = 1'b0;
    logic [7:0] throttle_pct = 8'h00;
    logic [3:0] gear_code = 4'h0;
    logic [3:0] mode_code = 4'h0;
    logic [7:0] flag_bits = 8'h00;
    logic       brake_on = 1'b0;
    logic       sink_accepts = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [6:0] throttle_out;
    logic [3:0] gear_out;
    logic [3:0] mode_out;
    logic       brake_out;
    logic [7:0] alive_out;

    // mirror of the block's registers and state
    logic [7:0] period_reg = pcfc_pkg::DEFAULT_PERIOD;
    logic       on_change_reg = 1'b0;
    logic [7:0] modulus_reg = pcfc_pkg::DEFAULT_MODULUS;
    logic [7:0] tick_budget = 8'd0;
    logic [7:0] alive_count = 8'd0;
    logic       have_sent = 1'b0;
    tick_t      last_sent = '0;

    frame_t frames_due[$];
    frame_t due;
    int     mismatch_count = 0;
    int     tx_idle_pct = 25;
    int     rx_idle_pct = 25;

    periodic_command_frame_composer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_valid (sample_valid),
        .throttle_pct (throttle_pct),
        .gear_code    (gear_code),
        .mode_code    (mode_code),
        .flag_bits    (flag_bits),
        .brake_on     (brake_on),
        .sink_accepts (sink_accepts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .throttle_out (throttle_out),
        .gear_out     (gear_out),
        .mode_out     (mode_out),
        .brake_out    (brake_out),
        .alive_out    (alive_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit compose_frame(input tick_t t, output frame_t f);
        logic [7:0] period;
        logic [7:0] modulus;
        f = '0;
        period = (period_reg == 8'd0) ? pcfc_pkg::DEFAULT_PERIOD : period_reg;
        modulus = (modulus_reg == 8'd0) ? pcfc_pkg::DEFAULT_MODULUS : modulus_reg;
        if (tick_budget < period - 8'd1)
        begin
            tick_budget = tick_budget + 8'd1;
            return 1'b0;
        end
        tick_budget = 8'd0;
        if (!t.sample_valid)
            return 1'b0;
        if (on_change_reg && have_sent && t.throttle == last_sent.throttle
            && t.gear == last_sent.gear && t.mode == last_sent.mode
            && t.flags == last_sent.flags && t.brake == last_sent.brake)
            return 1'b0;
        f.throttle = (t.throttle > 8'(pcfc_pkg::THROTTLE_MAX))
                     ? pcfc_pkg::THROTTLE_MAX : t.throttle[6:0];
        f.gear = t.gear;
        f.mode = t.mode;
        f.brake = t.brake;
        f.alive = alive_count % modulus;
        if (t.accept)
        begin
            alive_count = alive_count + 8'd1;
            have_sent = 1'b1;
            last_sent = t;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] random_throttle();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(95, 105));
            1: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly repeats or near-repeats so that change detection gets exercised
    function automatic tick_t next_tick(input tick_t cur);
        tick_t t;
        int    pick;
        t = cur;
        pick = $urandom_range(0, 9);
        if (pick >= 4 && pick <= 5)
        begin
            case ($urandom_range(0, 4))
                0: t.throttle = random_throttle();
                1: t.gear = 4'($urandom_range(0, 15));
                2: t.mode = 4'($urandom_range(0, 15));
                3: t.flags = t.flags ^ (8'd1 << $urandom_range(0, 7));
                default: t.brake = ~t.brake;
            endcase
        end
        else if (pick > 5)
        begin
            t.throttle = random_throttle();
            t.gear = 4'($urandom_range(0, 15));
            t.mode = 4'($urandom_range(0, 15));
            t.flags = 8'($urandom_range(0, 255));
            t.brake = 1'($urandom_range(0, 1));
        end
        t.sample_valid = ($urandom_range(0, 99) < 90);
        t.accept = ($urandom_range(0, 99) < 75);
        return t;
    endfunction

    task automatic drive_tick(input tick_t t, output bit emits, output frame_t f);
        @(negedge clk);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_valid <= t.sample_valid;
        throttle_pct <= t.throttle;
        gear_code <= t.gear;
        mode_code <= t.mode;
        flag_bits <= t.flags;
        brake_on <= t.brake;
        sink_accepts <= t.accept;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        emits = compose_frame(t, f);
    endtask

    task automatic park_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            pcfc_pkg::REG_MIN_PERIOD: period_reg = data;
            pcfc_pkg::REG_ON_CHANGE:  on_change_reg = data[0];
            pcfc_pkg::REG_ALIVE_MOD:  modulus_reg = data;
            default: ;
        endcase
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (frames_due.size() == 0)
            begin
                $error("unexpected frame: throttle %0d alive %0d", throttle_out, alive_out);
                mismatch_count++;
            end
            else
            begin
                due = frames_due.pop_front();
                if (throttle_out !== due.throttle)
                begin
                    $error("throttle_out: expected %0d, got %0d", due.throttle, throttle_out);
                    mismatch_count++;
                end
                if (gear_out !== due.gear)
                begin
                    $error("gear_out: expected %0d, got %0d", due.gear, gear_out);
                    mismatch_count++;
                end
                if (mode_out !== due.mode)
                begin
                    $error("mode_out: expected %0d, got %0d", due.mode, mode_out);
                    mismatch_count++;
                end
                if (brake_out !== due.brake)
                begin
                    $error("brake_out: expected %0d, got %0d", due.brake, brake_out);
                    mismatch_count++;
                end
                if (alive_out !== due.alive)
                begin
                    $error("alive_out: expected %0d, got %0d", due.alive, alive_out);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        row_t       step_row;
        tick_t      cur;
        frame_t     f;
        bit         emits;
        logic [7:0] period_pick;
        logic [7:0] modulus_pick;
        int         waited;

        cur = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            step_row = DIRECTED[i];
            if (step_row.kind == ROW_CFG)
            begin
                park_until_drained();
                write_reg(step_row.idx, step_row.data);
            end
            else
            begin
                drive_tick(step_row.tick, emits, f);
                case (step_row.kind)
                    ROW_FRAME:   frames_due.push_back(step_row.frame);
                    ROW_PREDICT: if (emits) frames_due.push_back(f);
                    default: ;
                endcase
            end
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            park_until_drained();
            tx_idle_pct = (p == 3) ? 0 : 25;
            rx_idle_pct = (p == 3) ? 0 : 25;
            case (p)
                0:
                begin
                    period_pick = 8'd0;
                    modulus_pick = 8'd0;
                end
                1:
                begin
                    period_pick = 8'd255;
                    modulus_pick = 8'd1;
                end
                2:
                begin
                    period_pick = 8'd1;
                    modulus_pick = 8'd255;
                end
                default:
                begin
                    period_pick = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(1, 3))
                                                               : 8'($urandom_range(0, 12));
                    modulus_pick = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(2, 20))
                                                               : 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(pcfc_pkg::REG_MIN_PERIOD, period_pick);
            write_reg(pcfc_pkg::REG_ON_CHANGE, 8'($urandom_range(0, 255)));
            write_reg(pcfc_pkg::REG_ALIVE_MOD, modulus_pick);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                cur = next_tick(cur);
                drive_tick(cur, emits, f);
                if (emits)
                    frames_due.push_back(f);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (frames_due.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        if (frames_due.size() != 0)
        begin
            $error("%0d frames never arrived", frames_due.size());
            mismatch_count++;
        end
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pcfc_pkg.sv
rtl/pcfc_ctrl.sv
rtl/pcfc_dp.sv
rtl/periodic_command_frame_composer.sv
rtl/pcfc_checker.sv
tb/tb_periodic_command_frame_composer.sv
